@@ hw/rtl/pfc_pkg.sv @@
package pfc_pkg;

  localparam logic [4:0] LET_J    = 5'd9;
  localparam logic [4:0] LET_X    = 5'd23;
  localparam logic [4:0] LET_Z    = 5'd25;
  localparam logic [2:0] LAST_IDX = 3'd4;
  localparam logic [4:0] CELLS    = 5'd25;
  localparam logic [4:0] ALPHA    = 5'd26;
  localparam int         SQ_DEPTH  = 25;
  localparam int         POS_DEPTH = 26;

  typedef enum logic [2:0] {
    REQ_NEW_KEY    = 3'd0,
    REQ_KEY_LETTER = 3'd1,
    REQ_KEY_DONE   = 3'd2,
    REQ_DATA       = 3'd3,
    REQ_END        = 3'd4
  } req_t;

  typedef struct packed {
    logic key_ready;
    logic pending_valid;
    logic letter_ok;
    logic key_place_ok;
    logic scan_place_ok;
    logic scan_done;
    logic slot_free;
  } status_t;

  typedef struct packed {
    logic clear_key;
    logic place_key;
    logic scan_start;
    logic scan_place;
    logic scan_step;
    logic finish_key;
    logic set_pending;
    logic pair_data;
    logic pair_end;
    logic rd_pos_a;
    logic rd_pos_b;
    logic rd_sq_a;
    logic rd_sq_b;
    logic load_first;
    logic load_second;
    logic load_err;
  } cmd_t;

  // Row of a cell index 0..24.
  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
    return 5'({r, 2'b00} + {2'b00, r} + {2'b00, c});
  endfunction

  function automatic logic [2:0] cell_col(input logic [4:0] p);
    logic [4:0] base;
    base = cell_addr(cell_row(p), 3'd0);
    return 3'(p - base);
  endfunction

  // Cyclic step along a row or column: forward when encrypting, back when decrypting.
  function automatic logic [2:0] step_idx(input logic [2:0] v, input logic dec);
    logic [2:0] s;
    if (dec) s = (v == 3'd0) ? LAST_IDX : 3'(v - 3'd1);
    else s = (v == LAST_IDX) ? 3'd0 : 3'(v + 3'd1);
    return s;
  endfunction

  function automatic logic [4:0] pad_for(input logic [4:0] l);
    return (l == LET_Z) ? LET_X : LET_Z;
  endfunction

endpackage

@@ hw/rtl/pfc_if.sv @@
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [4:0] letter;
  modport source(output valid, req_type, letter, input ready);
  modport sink(input valid, req_type, letter, output ready);
endinterface

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_letter;
  logic       last;
  logic       error;
  modport source(output valid, out_letter, last, error, input ready);
  modport sink(input valid, out_letter, last, error, output ready);
endinterface

interface pfc_cfg_if;
  logic valid;
  logic ready;
  logic decrypt_mode;
  modport source(output valid, decrypt_mode, input ready);
  modport sink(input valid, decrypt_mode, output ready);
endinterface

@@ hw/rtl/pfc_ram.sv @@
module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/pfc_ctrl.sv @@
module pfc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        req_type,
  output logic              in_ready,
  input  pfc_pkg::status_t  status,
  output pfc_pkg::cmd_t     cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FILL  = 9'b000000010,
    ST_LOOKA = 9'b000000100,
    ST_LOOKB = 9'b000001000,
    ST_SQA   = 9'b000010000,
    ST_SQB   = 9'b000100000,
    ST_EMITA = 9'b001000000,
    ST_EMITB = 9'b010000000,
    ST_ERR   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (pfc_pkg::req_t'(req_type))
            pfc_pkg::REQ_NEW_KEY: begin
              cmd.clear_key = 1'b1;
            end
            pfc_pkg::REQ_KEY_LETTER: begin
              if (!status.key_ready && status.key_place_ok) begin
                cmd.place_key = 1'b1;
              end
            end
            pfc_pkg::REQ_KEY_DONE: begin
              if (!status.key_ready) begin
                cmd.scan_start = 1'b1;
                state_next     = ST_FILL;
              end
            end
            pfc_pkg::REQ_DATA: begin
              if (!status.key_ready) begin
                state_next = ST_ERR;
              end else if (status.letter_ok) begin
                if (!status.pending_valid) begin
                  cmd.set_pending = 1'b1;
                end else begin
                  cmd.pair_data = 1'b1;
                  state_next    = ST_LOOKA;
                end
              end
            end
            pfc_pkg::REQ_END: begin
              if (status.key_ready && status.pending_valid) begin
                cmd.pair_end = 1'b1;
                state_next   = ST_LOOKA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd.scan_place = status.scan_place_ok;
        if (status.scan_done) begin
          cmd.finish_key = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_LOOKA: begin
        cmd.rd_pos_a = 1'b1;
        state_next   = ST_LOOKB;
      end
      ST_LOOKB: begin
        cmd.rd_pos_b = 1'b1;
        state_next   = ST_SQA;
      end
      ST_SQA: begin
        cmd.rd_sq_a = 1'b1;
        state_next  = ST_SQB;
      end
      ST_SQB: begin
        cmd.rd_sq_b = 1'b1;
        state_next  = ST_EMITA;
      end
      ST_EMITA: begin
        if (status.slot_free) begin
          cmd.load_first = 1'b1;
          state_next     = ST_EMITB;
        end
      end
      ST_EMITB: begin
        if (status.slot_free) begin
          cmd.load_second = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (status.slot_free) begin
          cmd.load_err = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/pfc_dp.sv @@
module pfc_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [4:0]        letter,
  input  logic              cfg_we,
  input  logic              cfg_decrypt,
  input  pfc_pkg::cmd_t     cmd,
  output pfc_pkg::status_t  status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4:0]        out_letter,
  output logic              out_last,
  output logic              out_error
);

  logic                       decrypt_mode;
  logic [pfc_pkg::POS_DEPTH-1:0] used;
  logic [4:0]                 cells_filled;
  logic                       key_ready;
  logic                       pending_valid;
  logic [4:0]                 pending_letter;
  logic [4:0]                 scan_idx;
  logic [4:0]                 pair_a;
  logic [4:0]                 pair_b;
  logic [4:0]                 pa;
  logic [4:0]                 oa;

  logic       letter_ok;
  logic       letter_used;
  logic       cells_full;
  logic       wr_en;
  logic [4:0] wr_letter;
  logic       pos_re;
  logic [4:0] pos_raddr;
  logic [4:0] pos_rdata;
  logic       sq_re;
  logic [4:0] sq_raddr;
  logic [4:0] sq_rdata;
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] oa_addr, ob_addr;
  logic       slot_free;

  assign letter_ok   = (letter < pfc_pkg::ALPHA) && (letter != pfc_pkg::LET_J);
  assign letter_used = letter_ok ? used[letter] : 1'b1;
  assign cells_full  = (cells_filled == pfc_pkg::CELLS);
  assign slot_free   = !out_valid || out_ready;

  always_comb begin
    status               = '0;
    status.key_ready     = key_ready;
    status.pending_valid = pending_valid;
    status.letter_ok     = letter_ok;
    status.key_place_ok  = letter_ok && !letter_used && !cells_full;
    status.scan_place_ok = (scan_idx != pfc_pkg::LET_J) && !used[scan_idx] && !cells_full;
    status.scan_done     = (scan_idx == pfc_pkg::LET_Z);
    status.slot_free     = slot_free;
  end

  assign wr_en     = cmd.place_key || cmd.scan_place;
  assign wr_letter = cmd.scan_place ? scan_idx : letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode   <= 1'b0;
      used           <= '0;
      cells_filled   <= '0;
      key_ready      <= 1'b0;
      pending_valid  <= 1'b0;
      pending_letter <= '0;
      scan_idx       <= '0;
    end else begin
      if (cfg_we) begin
        decrypt_mode <= cfg_decrypt;
      end
      if (cmd.clear_key) begin
        used           <= '0;
        cells_filled   <= '0;
        key_ready      <= 1'b0;
        pending_valid  <= 1'b0;
        pending_letter <= '0;
      end
      if (wr_en) begin
        used[wr_letter] <= 1'b1;
        cells_filled    <= 5'(cells_filled + 5'd1);
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= 5'(scan_idx + 5'd1);
      end
      if (cmd.finish_key) begin
        key_ready     <= 1'b1;
        pending_valid <= 1'b0;
      end
      if (cmd.set_pending) begin
        pending_valid  <= 1'b1;
        pending_letter <= letter;
      end
      // A repeated letter keeps its place as the first letter of the next pair.
      if (cmd.pair_data && (letter != pending_letter)) begin
        pending_valid <= 1'b0;
      end
      if (cmd.pair_end) begin
        pending_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_data) begin
      if (letter == pending_letter) begin
        pair_a <= letter;
        pair_b <= pfc_pkg::pad_for(letter);
      end else begin
        pair_a <= pending_letter;
        pair_b <= letter;
      end
    end else if (cmd.pair_end) begin
      pair_a <= pending_letter;
      pair_b <= pfc_pkg::pad_for(pending_letter);
    end
    if (cmd.rd_pos_b) begin
      pa <= pos_rdata;
    end
    if (cmd.rd_sq_b) begin
      oa <= sq_rdata;
    end
  end

  assign pos_re    = cmd.rd_pos_a || cmd.rd_pos_b;
  assign pos_raddr = cmd.rd_pos_b ? pair_b : pair_a;

  pfc_ram #(.WIDTH(5), .DEPTH(pfc_pkg::POS_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_letter),
    .wdata (cells_filled),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // The second position read stays on the RAM output while the square is read.
  always_comb begin
    ra = pfc_pkg::cell_row(pa);
    ca = pfc_pkg::cell_col(pa);
    rb = pfc_pkg::cell_row(pos_rdata);
    cb = pfc_pkg::cell_col(pos_rdata);
    if (ra == rb) begin
      oa_addr = pfc_pkg::cell_addr(ra, pfc_pkg::step_idx(ca, decrypt_mode));
      ob_addr = pfc_pkg::cell_addr(rb, pfc_pkg::step_idx(cb, decrypt_mode));
    end else if (ca == cb) begin
      oa_addr = pfc_pkg::cell_addr(pfc_pkg::step_idx(ra, decrypt_mode), ca);
      ob_addr = pfc_pkg::cell_addr(pfc_pkg::step_idx(rb, decrypt_mode), cb);
    end else begin
      oa_addr = pfc_pkg::cell_addr(ra, cb);
      ob_addr = pfc_pkg::cell_addr(rb, ca);
    end
  end

  assign sq_re    = cmd.rd_sq_a || cmd.rd_sq_b;
  assign sq_raddr = cmd.rd_sq_b ? ob_addr : oa_addr;

  pfc_ram #(.WIDTH(5), .DEPTH(pfc_pkg::SQ_DEPTH)) u_sq_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cells_filled),
    .wdata (wr_letter),
    .re    (sq_re),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_first || cmd.load_second || cmd.load_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      out_letter <= oa;
      out_last   <= 1'b0;
      out_error  <= 1'b0;
    end else if (cmd.load_second) begin
      out_letter <= sq_rdata;
      out_last   <= 1'b1;
      out_error  <= 1'b0;
    end else if (cmd.load_err) begin
      out_letter <= '0;
      out_last   <= 1'b1;
      out_error  <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/playfair_cipher_stream_top.sv @@
// Playfair cipher over a stream of letter indices (a=0 .. z=25).
// data_in carries requests (new key, key letter, key done, data letter,
// end of message) with a letter; data_out carries result letters with last
// and error flags; cfg writes decrypt_mode and is always ready, to be used
// only while the block is idle.
// A request is taken when data_in valid and ready are both high. Key letters,
// new key and unpaired data letters are handled in the idle state. Key done
// walks the alphabet once through the key store. A data letter that closes
// a pair, or end of message with a letter pending, takes two position reads
// and two square reads on memories with one read port, in states LOOKA,
// LOOKB, SQA and SQB; the first result enters the output register from EMITA
// and the second from EMITB. Data before the key is done gives one error
// result that enters the output register from the error state.
// The output register holds a result until data_out ready; while it is full
// the controller waits and data_in ready stays low until the last result of
// the current request is in the register.
// Synchronous reset clears the key, the pending letter, decrypt_mode and the
// output valid; no memory clearing pass is needed.
module playfair_cipher_stream_top (
  input  logic        clk,
  input  logic        rst,
  pfc_cfg_if.sink     cfg,
  pfc_in_if.sink      data_in,
  pfc_out_if.source   data_out
);

  pfc_pkg::status_t status;
  pfc_pkg::cmd_t    cmd;

  assign cfg.ready = 1'b1;

  pfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (data_in.valid),
    .req_type (data_in.req_type),
    .in_ready (data_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .letter      (data_in.letter),
    .cfg_we      (cfg.valid),
    .cfg_decrypt (cfg.decrypt_mode),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (data_out.valid),
    .out_ready   (data_out.ready),
    .out_letter  (data_out.out_letter),
    .out_last    (data_out.last),
    .out_error   (data_out.error)
  );

endmodule
